/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define XCFE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define XCFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also checks across reset.
`define XCFE_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/xcfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfe_pkg
// Types and constants for the XOR checksum frame encoder.
// ----------------------------------------------------------------------------
package xcfe_pkg;

  localparam logic [7:0] SOF_BYTE = 8'hFE;

  // input opcodes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // command queue sizing
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // byte position within one command
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] IDX_SOF      = 3'd0;
  localparam logic [IDX_W-1:0] IDX_FUNC_HI  = 3'd1;
  localparam logic [IDX_W-1:0] IDX_FUNC_LO  = 3'd2;
  localparam logic [IDX_W-1:0] IDX_LEN_HI   = 3'd3;
  localparam logic [IDX_W-1:0] IDX_LEN_LO   = 3'd4;
  localparam logic [IDX_W-1:0] IDX_HDR_SUM  = 3'd5;
  localparam logic [IDX_W-1:0] IDX_PAY_BYTE = 3'd0;
  localparam logic [IDX_W-1:0] IDX_PAY_SUM  = 3'd1;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        with_sum;
    logic [15:0] function_code;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic [7:0]  checksum;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* sv/xcfe_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfe_if
// Valid/ready channels for the frame encoder: input items and wire bytes.
// ----------------------------------------------------------------------------
interface xcfe_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] function_code;
  logic [15:0] payload_length;
  logic [7:0]  payload_byte;

  modport source (
    output valid, opcode, function_code, payload_length, payload_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, function_code, payload_length, payload_byte,
    output ready
  );
endinterface

interface xcfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       frame_end;

  modport source (
    output valid, out_byte, last_of_run, frame_end,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last_of_run, frame_end,
    output ready
  );
endinterface

/* sv/xcfe_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfe_front
// Accepts items, tracks frame state and the running XOR, queues commands.
// ----------------------------------------------------------------------------
module xcfe_front (
  input  logic                clk,
  input  logic                rst,
  xcfe_in_if.sink             items,
  input  xcfe_pkg::q_status_t q_status,
  output logic                push,
  output xcfe_pkg::cmd_t      push_cmd
);
  import xcfe_pkg::*;

  logic        frame_open, frame_open_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [7:0]  running_xor, running_xor_next;
  logic        take;
  logic [7:0]  hdr_xor;
  logic [7:0]  pay_xor;

  assign items.ready = !q_status.full;
  assign take        = items.valid && items.ready;

  assign hdr_xor = SOF_BYTE ^ items.function_code[15:8] ^ items.function_code[7:0]
                 ^ items.payload_length[15:8] ^ items.payload_length[7:0];
  assign pay_xor = running_xor ^ items.payload_byte;

  always_comb begin
    frame_open_next        = frame_open;
    bytes_remaining_next   = bytes_remaining;
    running_xor_next       = running_xor;
    push                   = 1'b0;
    push_cmd.kind          = KIND_HEADER;
    push_cmd.with_sum      = 1'b0;
    push_cmd.function_code = items.function_code;
    push_cmd.payload_length = items.payload_length;
    push_cmd.payload_byte  = items.payload_byte;
    push_cmd.checksum      = hdr_xor;
    if (take) begin
      case (items.opcode)
        OP_START: begin
          push             = 1'b1;
          running_xor_next = hdr_xor;
          if (items.payload_length == 16'd0) begin
            push_cmd.with_sum    = 1'b1;
            frame_open_next      = 1'b0;
            bytes_remaining_next = 16'd0;
          end else begin
            frame_open_next      = 1'b1;
            bytes_remaining_next = items.payload_length;
          end
        end
        OP_PAYLOAD: begin
          // no open frame: byte dropped, nothing queued
          if (frame_open) begin
            push                 = 1'b1;
            push_cmd.kind        = KIND_PAYLOAD;
            push_cmd.checksum    = pay_xor;
            running_xor_next     = pay_xor;
            bytes_remaining_next = bytes_remaining - 16'd1;
            if (bytes_remaining == 16'd1) begin
              push_cmd.with_sum = 1'b1;
              frame_open_next   = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open      <= 1'b0;
      bytes_remaining <= 16'd0;
      running_xor     <= 8'd0;
    end else begin
      frame_open      <= frame_open_next;
      bytes_remaining <= bytes_remaining_next;
      running_xor     <= running_xor_next;
    end
  end

endmodule

/* sv/xcfe_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfe_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module xcfe_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  xcfe_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output xcfe_pkg::cmd_t      head,
  output xcfe_pkg::q_status_t status
);
  import xcfe_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else                               r = p + QPTR_W'(1);
    return r;
  endfunction

  assign head         = entries[rd_ptr];
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/xcfe_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfe_back
// Expands queued commands into wire bytes through an output register.
// ----------------------------------------------------------------------------
module xcfe_back (
  input  logic                clk,
  input  logic                rst,
  input  xcfe_pkg::cmd_t      head,
  input  xcfe_pkg::q_status_t q_status,
  output logic                pop,
  xcfe_out_if.source          frames
);
  import xcfe_pkg::*;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] last_idx;
  logic [7:0]       cur_byte;
  logic             cur_is_sum;
  logic             advance;
  logic             issue;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_last;
  logic             out_end;

  assign advance = !out_valid || frames.ready;
  assign issue   = advance && !q_status.empty;

  always_comb begin
    if (head.kind == KIND_HEADER) begin
      last_idx = head.with_sum ? IDX_HDR_SUM : IDX_LEN_LO;
      case (idx)
        IDX_SOF:     cur_byte = SOF_BYTE;
        IDX_FUNC_HI: cur_byte = head.function_code[15:8];
        IDX_FUNC_LO: cur_byte = head.function_code[7:0];
        IDX_LEN_HI:  cur_byte = head.payload_length[15:8];
        IDX_LEN_LO:  cur_byte = head.payload_length[7:0];
        default:     cur_byte = head.checksum;
      endcase
    end else begin
      last_idx = head.with_sum ? IDX_PAY_SUM : IDX_PAY_BYTE;
      cur_byte = (idx == IDX_PAY_BYTE) ? head.payload_byte : head.checksum;
    end
  end

  assign cur_is_sum = head.with_sum && (idx == last_idx);
  assign pop        = issue && (idx == last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (issue) idx <= pop ? '0 : idx + IDX_W'(1);
      if (advance) out_valid <= !q_status.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_byte <= cur_byte;
      out_last <= (idx == last_idx);
      out_end  <= cur_is_sum;
    end
  end

  assign frames.valid       = out_valid;
  assign frames.out_byte    = out_byte;
  assign frames.last_of_run = out_last;
  assign frames.frame_end   = out_end;

endmodule

/* sv/xor_checksum_frame_encoder_unit.sv */
`timescale 1ns / 1ps
// The first wire byte of an item is registered in the command queue, then in the output register.
// Throughput: one wire byte per cycle from the back end unless the queue is empty or the output stalls;
//   a payload item is 1 byte (2 if it closes the frame), a start item 5 bytes (6 for a zero length).
// The front takes one item per cycle while the 2-entry command queue has room.
// Reset (rst, synchronous, high) closes any frame, clears the checksum and empties
//   the queue and the output register.
// ----------------------------------------------------------------------------
// xor_checksum_frame_encoder_unit
// Serial frame encoder: start byte, function code, length, payload, XOR sum.
// ----------------------------------------------------------------------------
module xor_checksum_frame_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  xcfe_in_if.sink     items,
  xcfe_out_if.source  frames
);
  import xcfe_pkg::*;

  // Front: owns frame_open, bytes_remaining and the running XOR. Since every
  // byte of a command is known when its item is accepted, the checksum is
  // already final when the command is queued, so the back never feeds
  // anything back to the front.
  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      head;
  q_status_t q_status;

  xcfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Queue decouples item acceptance from byte emission: a header burst on
  // the wire does not stop the front from taking the next item while the queue has room.
  xcfe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Back: walks the head command byte by byte into the output register;
  // pops the command with its last byte.
  xcfe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .frames   (frames)
  );

endmodule

/* sv/xcfe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfe_checker
// Port-level checks on the encoder's output stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xcfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run,
  input logic       frame_end
);
  import xcfe_pkg::*;

  logic after_end;
  logic out_xfer;

  assign out_xfer = out_valid && out_ready;

  // set by a checksum transaction, cleared by the next transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      after_end <= 1'b0;
    end else if (out_xfer) begin
      after_end <= frame_end;
    end
  end

  `XCFE_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last_of_run) && $stable(frame_end), "output changed while stalled")
  `XCFE_ASSERT_NOW(a_sum_is_last, clk, rst, out_valid && frame_end, last_of_run, "checksum byte not last of its run")
  `XCFE_ASSERT_NOW(a_sof_after_end, clk, rst, out_valid && after_end, out_byte == SOF_BYTE, "byte after a checksum is not a start byte")
  `XCFE_ASSERT_ALWAYS_NEXT(a_reset_idle, clk, rst, !out_valid, "output valid right after reset")

endmodule

bind xor_checksum_frame_encoder_unit xcfe_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (frames.valid),
  .out_ready   (frames.ready),
  .out_byte    (frames.out_byte),
  .last_of_run (frames.last_of_run),
  .frame_end   (frames.frame_end)
);
